@@ rtl/scc_pkg.sv @@
// Shared types and constants for the space curve curvature pipeline.
// No dependencies.
`default_nettype none
package scc_pkg;
   localparam int QUOT_WIDTH = 32;
   localparam int CSR_WIDTH  = 32;

   typedef struct packed {
      logic too_slow;
      logic sat;
   } flags_type;
endpackage
`default_nettype wire

@@ rtl/scc_front.sv @@
// Front pipeline: products, speed squared, cross magnitudes, |v x a|^2, speed^6,
// floor and overflow checks. Uses scc_pkg.
`default_nettype none
module scc_front import scc_pkg::*; #(
   parameter int CW = 16,
   parameter int F  = 12,
   parameter int EW = 4 * CW + QUOT_WIDTH + 2 * F,
   parameter int VW = 6 * CW
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [CSR_WIDTH-1:0] floor_val,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire logic signed [CW-1:0] v0,
   input  wire logic signed [CW-1:0] v1,
   input  wire logic signed [CW-1:0] v2,
   input  wire logic signed [CW-1:0] a0,
   input  wire logic signed [CW-1:0] a1,
   input  wire logic signed [CW-1:0] a2,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output logic [EW-1:0]             out_e,
   output logic [VW-1:0]             out_v,
   output flags_type                 out_flags
);
   localparam int PW  = 2 * CW;
   localparam int C2W = 4 * CW;
   localparam int SHW = QUOT_WIDTH + 2 * F;
   localparam int LW  = VW + 2 * QUOT_WIDTH;
   localparam int MW  = (LW > EW) ? LW : EW;
   localparam int FW  = (PW > CSR_WIDTH) ? PW : CSR_WIDTH;

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic r1, r2, r3, r4, r5, r6;

   assign r6 = !v6_ff || out_ready;
   assign r5 = !v5_ff || r6;
   assign r4 = !v4_ff || r5;
   assign r3 = !v3_ff || r4;
   assign r2 = !v2_ff || r3;
   assign r1 = !v1_ff || r2;
   assign in_ready = r1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         if (r1) v1_ff <= in_valid;
         if (r2) v2_ff <= v1_ff;
         if (r3) v3_ff <= v2_ff;
         if (r4) v4_ff <= v3_ff;
         if (r5) v5_ff <= v4_ff;
         if (r6) v6_ff <= v5_ff;
      end
   end

   // stage 1: products
   logic signed [PW-1:0] sq_ff [3];
   logic signed [PW-1:0] pr_ff [6];
   always_ff @(posedge clock) begin
      if (r1) begin
         sq_ff[0] <= v0 * v0;
         sq_ff[1] <= v1 * v1;
         sq_ff[2] <= v2 * v2;
         pr_ff[0] <= v1 * a2;
         pr_ff[1] <= v2 * a1;
         pr_ff[2] <= v2 * a0;
         pr_ff[3] <= v0 * a2;
         pr_ff[4] <= v0 * a1;
         pr_ff[5] <= v1 * a0;
      end
   end

   // stage 2: speed squared, cross magnitudes, floor check
   logic [PW-1:0]        spd_in, spd_ff;
   logic [PW-1:0]        mag_in [3];
   logic [PW-1:0]        mag_ff [3];
   logic signed [PW:0]   dif [3];
   logic                 slow2_in, slow2_ff;
   always_comb begin
      spd_in = PW'(unsigned'(sq_ff[0])) + PW'(unsigned'(sq_ff[1]))
             + PW'(unsigned'(sq_ff[2]));
      for (int i = 0; i < 3; i++) begin
         dif[i] = PW'(0) + ((PW+1)'(pr_ff[2*i]) - (PW+1)'(pr_ff[2*i+1]));
         mag_in[i] = dif[i][PW] ? PW'(-dif[i]) : PW'(dif[i]);
      end
      slow2_in = FW'(spd_in) <= FW'(floor_val);
   end
   always_ff @(posedge clock) begin
      if (r2) begin
         spd_ff   <= spd_in;
         mag_ff   <= mag_in;
         slow2_ff <= slow2_in;
      end
   end

   // stage 3: squares
   logic [C2W-1:0] csq_ff [3];
   logic [C2W-1:0] s2_ff;
   logic [PW-1:0]  spd3_ff;
   logic           slow3_ff;
   always_ff @(posedge clock) begin
      if (r3) begin
         for (int i = 0; i < 3; i++) csq_ff[i] <= C2W'(mag_ff[i]) * C2W'(mag_ff[i]);
         s2_ff    <= C2W'(spd_ff) * C2W'(spd_ff);
         spd3_ff  <= spd_ff;
         slow3_ff <= slow2_ff;
      end
   end

   // stage 4: |v x a|^2 and the two halves of speed^6
   logic [C2W-1:0] c2_ff;
   logic [C2W-1:0] clo_ff, chi_ff;
   logic           slow4_ff;
   always_ff @(posedge clock) begin
      if (r4) begin
         c2_ff    <= csq_ff[0] + csq_ff[1] + csq_ff[2];
         clo_ff   <= C2W'(s2_ff[PW-1:0]) * C2W'(spd3_ff);
         chi_ff   <= C2W'(s2_ff[C2W-1:PW]) * C2W'(spd3_ff);
         slow4_ff <= slow3_ff;
      end
   end

   // stage 5: speed^6
   logic [C2W-1:0] c2b_ff;
   logic [VW-1:0]  cube_ff;
   logic           slow5_ff;
   always_ff @(posedge clock) begin
      if (r5) begin
         c2b_ff   <= c2_ff;
         cube_ff  <= VW'(clo_ff) + (VW'(chi_ff) << PW);
         slow5_ff <= slow4_ff;
      end
   end

   // stage 6: scaled numerator and overflow check
   logic [EW-1:0] rhs;
   logic [MW-1:0] lhs_x, rhs_x;
   always_comb begin
      rhs   = EW'(c2b_ff) << SHW;
      rhs_x = MW'(rhs);
      lhs_x = MW'(cube_ff) << (2 * QUOT_WIDTH);
   end
   logic [EW-1:0] e_ff;
   logic [VW-1:0] vv_ff;
   flags_type     fl_ff;
   always_ff @(posedge clock) begin
      if (r6) begin
         e_ff           <= rhs;
         vv_ff          <= cube_ff;
         fl_ff.too_slow <= slow5_ff;
         fl_ff.sat      <= lhs_x <= rhs_x;
      end
   end

   assign out_valid = v6_ff;
   assign out_e     = e_ff;
   assign out_v     = vv_ff;
   assign out_flags = fl_ff;
endmodule
`default_nettype wire

@@ rtl/scc_cell.sv @@
// One root-digit cell: tries quotient bit BIT against the running residual.
// Uses scc_pkg.
`default_nettype none
module scc_cell import scc_pkg::*; #(
   parameter int BIT = 31,
   parameter int EW  = 120,
   parameter int VW  = 96
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire logic [EW-1:0]         in_e,
   input  wire logic [VW+QUOT_WIDTH-1:0] in_p,
   input  wire logic [VW-1:0]         in_v,
   input  wire logic [QUOT_WIDTH-1:0] in_q,
   input  wire flags_type             in_flags,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output logic [EW-1:0]              out_e,
   output logic [VW+QUOT_WIDTH-1:0]   out_p,
   output logic [VW-1:0]              out_v,
   output logic [QUOT_WIDTH-1:0]      out_q,
   output flags_type                  out_flags
);
   localparam int PW  = VW + QUOT_WIDTH;
   localparam int DW0 = VW + 2 * QUOT_WIDTH + 2;
   localparam int XW  = ((DW0 > EW) ? DW0 : EW) + 1;

   logic          valid_ff;
   logic [EW-1:0] e_ff;
   logic [PW-1:0] p_ff;
   logic [VW-1:0] v_ff;
   logic [QUOT_WIDTH-1:0] q_ff;
   flags_type     fl_ff;

   // trial: (2*q*2^b + 2^2b) * V = (P << b+1) + (V << 2b)
   logic [XW-1:0] dlt, ex;
   logic          take;
   always_comb begin
      dlt  = (XW'(in_p) << (BIT + 1)) + (XW'(in_v) << (2 * BIT));
      ex   = XW'(in_e);
      take = dlt <= ex;
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         v_ff  <= in_v;
         fl_ff <= in_flags;
         if (take) begin
            e_ff <= EW'(ex - dlt);
            p_ff <= in_p + (PW'(in_v) << BIT);
            q_ff <= in_q | (QUOT_WIDTH'(1) << BIT);
         end else begin
            e_ff <= in_e;
            p_ff <= in_p;
            q_ff <= in_q;
         end
      end
   end

   assign out_valid = valid_ff;
   assign out_e     = e_ff;
   assign out_p     = p_ff;
   assign out_v     = v_ff;
   assign out_q     = q_ff;
   assign out_flags = fl_ff;
endmodule
`default_nettype wire

@@ rtl/space_curve_curvature.sv @@
// Curvature |v x a| / |v|^3 of a space curve, unsigned Q16.16, saturating.
// Pipeline: 6 front stages, then one cell per quotient bit (32).
// Throughput one transfer per cycle; each stage holds only when the next one is full and stalled.
// Synchronous active-high reset empties the pipeline and clears the speed-squared floor (floor_ff).
// Uses scc_pkg, scc_front and scc_cell.
`default_nettype none
module space_curve_curvature import scc_pkg::*; #(
   parameter int COMPONENT_WIDTH = 16,
   parameter int FRACTION_BITS   = 12
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic signed [COMPONENT_WIDTH-1:0] req_vel_v,
   input  wire logic signed [COMPONENT_WIDTH-1:0] req_vel_a,
   input  wire logic signed [COMPONENT_WIDTH-1:0] req_vel_d,
   input  wire logic signed [COMPONENT_WIDTH-1:0] req_acc_v,
   input  wire logic signed [COMPONENT_WIDTH-1:0] req_acc_a,
   input  wire logic signed [COMPONENT_WIDTH-1:0] req_acc_d,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [QUOT_WIDTH-1:0]                  rsp_curvature,
   output logic                                   rsp_saturated,
   output logic                                   rsp_too_slow,
   input  wire logic                              csr_we,
   input  wire logic [CSR_WIDTH-1:0]              csr_wdata
);
   localparam int EW = 4 * COMPONENT_WIDTH + QUOT_WIDTH + 2 * FRACTION_BITS;
   localparam int VW = 6 * COMPONENT_WIDTH;
   localparam int PW = VW + QUOT_WIDTH;

   logic [CSR_WIDTH-1:0] floor_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         floor_ff <= '0;
      end else if (csr_we) begin
         floor_ff <= csr_wdata;
      end
   end

   logic                  c_valid [QUOT_WIDTH+1];
   logic                  c_ready [QUOT_WIDTH+1];
   logic [EW-1:0]         c_e     [QUOT_WIDTH+1];
   logic [PW-1:0]         c_p     [QUOT_WIDTH+1];
   logic [VW-1:0]         c_v     [QUOT_WIDTH+1];
   logic [QUOT_WIDTH-1:0] c_q     [QUOT_WIDTH+1];
   flags_type             c_fl    [QUOT_WIDTH+1];

   scc_front #(
      .CW (COMPONENT_WIDTH),
      .F  (FRACTION_BITS),
      .EW (EW),
      .VW (VW)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .floor_val (floor_ff),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .v0        (req_vel_v),
      .v1        (req_vel_a),
      .v2        (req_vel_d),
      .a0        (req_acc_v),
      .a1        (req_acc_a),
      .a2        (req_acc_d),
      .out_valid (c_valid[0]),
      .out_ready (c_ready[0]),
      .out_e     (c_e[0]),
      .out_v     (c_v[0]),
      .out_flags (c_fl[0])
   );
   assign c_p[0] = '0;
   assign c_q[0] = '0;

   for (genvar i = 0; i < QUOT_WIDTH; i++) begin : g_cell
      scc_cell #(
         .BIT (QUOT_WIDTH - 1 - i),
         .EW  (EW),
         .VW  (VW)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (c_valid[i]),
         .in_ready  (c_ready[i]),
         .in_e      (c_e[i]),
         .in_p      (c_p[i]),
         .in_v      (c_v[i]),
         .in_q      (c_q[i]),
         .in_flags  (c_fl[i]),
         .out_valid (c_valid[i+1]),
         .out_ready (c_ready[i+1]),
         .out_e     (c_e[i+1]),
         .out_p     (c_p[i+1]),
         .out_v     (c_v[i+1]),
         .out_q     (c_q[i+1]),
         .out_flags (c_fl[i+1])
      );
   end

   assign c_ready[QUOT_WIDTH] = rsp_ready;
   assign rsp_valid = c_valid[QUOT_WIDTH];

   always_comb begin
      if (c_fl[QUOT_WIDTH].too_slow) begin
         rsp_curvature = '0;
         rsp_saturated = 1'b0;
         rsp_too_slow  = 1'b1;
      end else if (c_fl[QUOT_WIDTH].sat) begin
         rsp_curvature = '1;
         rsp_saturated = 1'b1;
         rsp_too_slow  = 1'b0;
      end else begin
         rsp_curvature = c_q[QUOT_WIDTH];
         rsp_saturated = 1'b0;
         rsp_too_slow  = 1'b0;
      end
   end
endmodule
`default_nettype wire
